// ===== hw/rtl/min_max_normalize_16_to_8_macros.svh =====
// Assertion macros shared by the min/max normaliser RTL.
// Needs nothing else; included by modules that carry assertions.
`ifndef MIN_MAX_NORMALIZE_16_TO_8_MACROS_SVH
`define MIN_MAX_NORMALIZE_16_TO_8_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mmn_pkg.sv =====
// Shared types and constants for the min/max normaliser.
// No dependencies; imported by every module of the block.
`default_nettype none

package mmn_pkg;

	localparam int MAX_VOXELS = 4096;
	localparam int ADDR_W     = $clog2(MAX_VOXELS);
	localparam int CNT_W      = $clog2(MAX_VOXELS + 1);
	localparam int VOX_W      = 16;
	localparam int RES_W      = 8;
	localparam int NUM_W      = VOX_W + RES_W;
	localparam int DIV_STEPS  = RES_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 2);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS + 1);

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_EMIT  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_DONE    = 2'd2;
	localparam logic [1:0] STAT_DROPPED = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic div_start;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic have_voxel;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mmn_div.sv =====
// Iterative ceiling divider with saturation: a saturation check, then one
// quotient bit per cycle. Uses mmn_pkg.
`default_nettype none

module mmn_div import mmn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [VOX_W-1:0] den,
	input  wire logic             zero,
	output logic                  done,
	output logic [RES_W-1:0]      result
);

	logic [NUM_W-1:0]     rem_q;
	logic [NUM_W-1:0]     dsh_q;
	logic [VOX_W-1:0]     den_q;
	logic [RES_W-1:0]     quo_q;
	logic                 sat_q;
	logic                 zero_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     lim;

	// 255 * den
	assign lim = {den_q, {RES_W{1'b0}}} - {{RES_W{1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= DIV_LAST;
		end else if (start) begin
			cnt_q <= '0;
		end else if (cnt_q != DIV_LAST) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			dsh_q  <= {{(RES_W-1){1'b0}}, den, 1'b0} >> 1 << (RES_W - 1);
			quo_q  <= '0;
			zero_q <= zero;
			sat_q  <= 1'b0;
		end else if (cnt_q == '0) begin
			// no division beyond 255 needed once saturation is known
			sat_q <= rem_q > lim;
		end else if (cnt_q != DIV_LAST) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[RES_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[RES_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = (cnt_q == DIV_LAST);

	always_comb begin
		if (zero_q) begin
			result = '0;
		end else if (sat_q) begin
			result = '1;
		end else begin
			result = quo_q + RES_W'(rem_q != '0);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mmn_datapath.sv =====
// Datapath: voxel store, count and read pointer, extremes, numerator
// set-up, divider and output register. Uses mmn_pkg, mmn_div, macros.
`default_nettype none
`include "min_max_normalize_16_to_8_macros.svh"

module mmn_datapath import mmn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire logic [1:0]       mode,
	input  wire logic [7:0]       low_byte,
	input  wire logic [7:0]       high_byte,
	output sts_t                  sts,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [RES_W-1:0]      scaled_value,
	output logic [1:0]            status,
	output logic                  last_voxel
);

	logic [VOX_W-1:0] mem [MAX_VOXELS];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic [VOX_W-1:0] min_q;
	logic [VOX_W-1:0] max_q;
	logic             drop_q;
	logic [VOX_W-1:0] rd_q;
	logic [VOX_W-1:0] lo_q;
	logic [VOX_W-1:0] den_q;
	logic             inv_q;
	logic             have_q;
	logic [1:0]       stat_q;
	logic             last_q;
	logic             out_valid_q;
	logic [RES_W-1:0] scaled_q;
	logic [1:0]       status_q;
	logic             last_voxel_q;

	logic [VOX_W-1:0] vin;
	logic             full;
	logic             have_voxel;
	logic             flat;
	logic [VOX_W-1:0] diff;
	logic [NUM_W-1:0] num;
	logic             zero;
	logic             div_done;
	logic [RES_W-1:0] div_result;

	assign vin        = {high_byte, low_byte};
	assign full       = (count_q == CNT_W'(MAX_VOXELS));
	assign have_voxel = (count_q != '0) && (ptr_q < count_q);
	assign flat       = (min_q == max_q);

	// store
	always_ff @(posedge clk) begin
		if (cmd.take && mode == MODE_LOAD && !full) begin
			mem[count_q[ADDR_W-1:0]] <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && mode == MODE_EMIT) begin
			rd_q <= mem[ptr_q[ADDR_W-1:0]];
		end
	end

	// counters and extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.take) begin
			unique case (mode)
				MODE_LOAD: begin
					if (full) begin
						drop_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
						if (vin < min_q) min_q <= vin;
						if (vin > max_q) max_q <= vin;
					end
				end
				MODE_EMIT: begin
					if (have_voxel) ptr_q <= ptr_q + 1'b1;
				end
				MODE_CLEAR: begin
					count_q <= '0;
					ptr_q   <= '0;
					min_q   <= '1;
					max_q   <= '0;
					drop_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// per-emit context, fixed at acceptance
	always_ff @(posedge clk) begin
		if (cmd.take && mode == MODE_EMIT) begin
			have_q <= have_voxel;
			last_q <= have_voxel && ((ptr_q + 1'b1) == count_q);
			lo_q   <= flat ? '0 : min_q;
			den_q  <= flat ? VOX_W'(1) : max_q - min_q;
			inv_q  <= !flat && (max_q < min_q);
			priority if (count_q == '0) stat_q <= STAT_EMPTY;
			else if (!have_voxel)       stat_q <= STAT_DONE;
			else if (drop_q)            stat_q <= STAT_DROPPED;
			else                        stat_q <= STAT_OK;
		end
	end

	// (v - lo) * 255 as a shift and subtract
	assign diff = rd_q - lo_q;
	assign num  = {diff, {RES_W{1'b0}}} - {{RES_W{1'b0}}, diff};
	assign zero = (rd_q <= lo_q) || inv_q;

	mmn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (den_q),
		.zero   (zero),
		.done   (div_done),
		.result (div_result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			scaled_q     <= have_q ? div_result : '0;
			status_q     <= stat_q;
			last_voxel_q <= last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign scaled_value = scaled_q;
	assign status       = status_q;
	assign last_voxel   = last_voxel_q;

	assign sts.have_voxel = have_voxel;
	assign sts.div_done   = div_done;
	assign sts.out_free   = !out_valid_q || !out_stall;

	`MMN_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, ptr_q <= count_q && !(count_q > CNT_W'(MAX_VOXELS)), "read pointer or count out of range")
	`MMN_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || !out_stall, "output register overwritten while held")
	`MMN_ASSERT_NOW(a_div_ready, clk, arst_n, cmd.out_load && have_q, div_done, "result loaded before divider finished")
	`MMN_ASSERT_NEXT(a_clear, clk, arst_n, cmd.take && mode == MODE_CLEAR, count_q == '0 && ptr_q == '0 && !drop_q, "clear did not empty the store")

endmodule

`default_nettype wire

// ===== hw/rtl/mmn_ctrl.sv =====
// Controller state machine: input acceptance and emit sequencing.
// Uses mmn_pkg; drives the datapath through cmd_t.
`default_nettype none

module mmn_ctrl import mmn_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] mode,
	output logic            in_stall,
	input  wire sts_t       sts,
	output cmd_t            cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   take;

	assign take     = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && mode == MODE_EMIT) begin
					state_d = sts.have_voxel ? ST_CALC : ST_FIN;
				end
			end
			ST_CALC: state_d = ST_DIV;
			ST_DIV:  if (sts.div_done) state_d = ST_FIN;
			ST_FIN:  if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.take      = take;
	assign cmd.div_start = (state_q == ST_CALC);
	assign cmd.out_load  = (state_q == ST_FIN) && sts.out_free;

endmodule

`default_nettype wire

// ===== hw/rtl/min_max_normalize_16_to_8.sv =====
// Min/max normaliser, top level: 16-bit voxels in, 8-bit scaled voxels out.
// Uses mmn_pkg, mmn_ctrl and mmn_datapath.
//
// Load items (mode 0) append {high_byte, low_byte} to a 4096-entry store and
// update the running minimum and maximum; a load into a full store is
// dropped and remembered. Emit items (mode 1) read the store back in load
// order and return ceil((v - min) * 255 / (max - min)), saturated at 255;
// flat data is scaled as if min were 0 and max 1. An emit with nothing
// loaded returns status 1, one past the last voxel status 2, and status 3
// marks a good result after drops. Clear (mode 2) empties the store and
// resets the extremes; mode 3 is accepted and does nothing. Only emits
// produce an item on the output.
// Sequencing: load, clear and mode 3 items leave the input unstalled. An emit
// that reads a voxel passes through the store read, the numerator set-up,
// the iterative divider (a saturation check then one quotient bit a cycle)
// and the output register load before the next item can be accepted; an
// emit that only reports a status goes straight to the output register
// load. The output register lets a result wait while the next item is
// accepted; input stalls only while an emit is in flight or its result
// cannot yet be placed. No clearing pass after reset.
`default_nettype none

module min_max_normalize_16_to_8 import mmn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// input channel
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       mode,
	input  wire logic [7:0]       low_byte,
	input  wire logic [7:0]       high_byte,
	// output channel
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [RES_W-1:0]      scaled_value,
	output logic [1:0]            status,
	output logic                  last_voxel
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: accepts items, steps an emit through read, divide, output
	mmn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, extremes, divider and the output register
	mmn_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (mode),
		.low_byte     (low_byte),
		.high_byte    (high_byte),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scaled_value (scaled_value),
		.status       (status),
		.last_voxel   (last_voxel)
	);

endmodule

`default_nettype wire
